// ----- hw/rtl/tsbg_pkg.sv -----
// ----------------------------------------------------------------------------
// tsbg_pkg
// Shared types and constants of the tempo-synced breakpoint gain block.
// ----------------------------------------------------------------------------
package tsbg_pkg;

	localparam int NUM_POINTS_DEF = 5;
	localparam int GROUP_SIZE_DEF = 8;
	localparam int MAX_POINTS     = 8;

	localparam int SAMPLE_W = 24;
	localparam int PHASE_W  = 16;
	localparam int FRAC_W   = 16;
	localparam int COORD_W  = 16;
	localparam int POINT_W  = 32;
	localparam int CFG_W    = 32;

	localparam logic [PHASE_W-1:0] PERIOD_RESET = 16'd6000;

	localparam logic [POINT_W-1:0] POINT_RESET [MAX_POINTS] = '{
		32'h0000_0000, 32'h4000_0000, 32'h4000_8000, 32'h8000_8000,
		32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000
	};

	localparam int QUEUE_DEPTH = 2;

	localparam int DIV_DVD_W          = 32;
	localparam int DIV_DSR_W          = 16;
	localparam int DIV_BITS_PER_CYCLE = 2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic        [PHASE_W-1:0]  phase;
	} item_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_stat_t;

	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
	} segment_t;

endpackage

// ----- hw/rtl/tempo_synced_breakpoint_gain.sv -----
// ----------------------------------------------------------------------------
// tempo_synced_breakpoint_gain
// Tempo-synced piecewise-linear tremolo on a stereo sample stream.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one stereo sample with the transport
// flag and beat fraction. Output channel: out_valid/out_stall carry the scaled
// pair, one result item per input item, in order.
// The front tracks the phase index as it accepts each item and pushes into a
// two-entry queue; the back works on one item at a time. Per item the back
// makes two passes of the shared divider (phase and interpolation) plus setup,
// multiply and output steps; flat segments skip the second divide, a zero
// period skips the first. The divider sets the throughput.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
// breakpoints use index 0..NUM_POINTS-1, the period index NUM_POINTS.
// Reset clears the phase index, sub-counter, transport flag and queue, and
// loads the default shape and period; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the back
// waits, the queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
module tempo_synced_breakpoint_gain #(
	parameter int NUM_POINTS = tsbg_pkg::NUM_POINTS_DEF,
	parameter int GROUP_SIZE = tsbg_pkg::GROUP_SIZE_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [$clog2(NUM_POINTS+1)-1:0]         cfg_index,
	input  logic [tsbg_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [tsbg_pkg::SAMPLE_W-1:0]    left_in,
	input  logic signed [tsbg_pkg::SAMPLE_W-1:0]    right_in,
	input  logic                                    playing,
	input  logic        [tsbg_pkg::FRAC_W-1:0]      beat_fraction,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [tsbg_pkg::SAMPLE_W-1:0]    left_out,
	output logic signed [tsbg_pkg::SAMPLE_W-1:0]    right_out
);

	localparam int IDX_W = $clog2(NUM_POINTS + 1);
	localparam logic [IDX_W-1:0] PERIOD_IDX = IDX_W'(NUM_POINTS);

	logic [NUM_POINTS-1:0][tsbg_pkg::POINT_W-1:0] points_q;
	logic [tsbg_pkg::PHASE_W-1:0]                 period_q;

	tsbg_pkg::queue_stat_t q_stat;
	tsbg_pkg::item_t       push_item;
	tsbg_pkg::item_t       q_head;
	logic                  push;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				points_q[i] <= tsbg_pkg::POINT_RESET[i];
			end
			period_q <= tsbg_pkg::PERIOD_RESET;
		end else if (cfg_write) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				if (cfg_index == IDX_W'(i)) begin
					points_q[i] <= cfg_data;
				end
			end
			if (cfg_index == PERIOD_IDX) begin
				period_q <= cfg_data[tsbg_pkg::PHASE_W-1:0];
			end
		end
	end

	tsbg_front #(
		.GROUP_SIZE (GROUP_SIZE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_in       (left_in),
		.right_in      (right_in),
		.playing       (playing),
		.beat_fraction (beat_fraction),
		.period        (period_q),
		.q_stat        (q_stat),
		.push          (push),
		.push_item     (push_item)
	);

	tsbg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	tsbg_back #(
		.NUM_POINTS (NUM_POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.points    (points_q),
		.period    (period_q),
		.q_stat    (q_stat),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out)
	);

endmodule

// ----- hw/rtl/tsbg_front.sv -----
// ----------------------------------------------------------------------------
// tsbg_front
// Accepts items, tracks transport and phase index, pushes the phase per item.
// ----------------------------------------------------------------------------
module tsbg_front #(
	parameter int GROUP_SIZE = tsbg_pkg::GROUP_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [tsbg_pkg::SAMPLE_W-1:0]  left_in,
	input  logic signed [tsbg_pkg::SAMPLE_W-1:0]  right_in,
	input  logic                                  playing,
	input  logic        [tsbg_pkg::FRAC_W-1:0]    beat_fraction,
	input  logic        [tsbg_pkg::PHASE_W-1:0]   period,
	input  tsbg_pkg::queue_stat_t                 q_stat,
	output logic                                  push,
	output tsbg_pkg::item_t                       push_item
);

	localparam int GC_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int GCN_W = GC_W + 1;
	localparam int PW    = tsbg_pkg::PHASE_W;

	logic [PW-1:0]                           phase_q;
	logic [GC_W-1:0]                         gc_q;
	logic                                    was_playing_q;
	logic [tsbg_pkg::FRAC_W+PW-1:0]          sync_prod;
	logic [PW-1:0]                           phase_w;
	logic [GCN_W-1:0]                        gc_next;
	logic                                    gc_wrap;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		sync_prod = beat_fraction * period;
		phase_w   = (playing && !was_playing_q) ? sync_prod[tsbg_pkg::FRAC_W+PW-1:tsbg_pkg::FRAC_W]
		                                        : phase_q;
		if (phase_w >= period) begin
			phase_w = '0;
		end
		gc_next = {1'b0, gc_q} + GCN_W'(1);
		gc_wrap = gc_next >= GCN_W'(GROUP_SIZE);
	end

	assign push_item.left  = left_in;
	assign push_item.right = right_in;
	assign push_item.phase = phase_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			gc_q          <= '0;
			was_playing_q <= 1'b0;
		end else if (push) begin
			was_playing_q <= playing;
			if (gc_wrap) begin
				gc_q    <= '0;
				phase_q <= phase_w + PW'(1);
			end else begin
				gc_q    <= gc_next[GC_W-1:0];
				phase_q <= phase_w;
			end
		end
	end

endmodule

// ----- hw/rtl/tsbg_queue.sv -----
// ----------------------------------------------------------------------------
// tsbg_queue
// Short item queue between front and back.
// ----------------------------------------------------------------------------
module tsbg_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tsbg_pkg::item_t       push_item,
	input  logic                  pop,
	output tsbg_pkg::item_t       head,
	output tsbg_pkg::queue_stat_t stat
);

	localparam int DEPTH = tsbg_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsbg_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/tsbg_div.sv -----
// ----------------------------------------------------------------------------
// tsbg_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tsbg_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tsbg_pkg::DIV_DVD_W-1:0]    dividend,
	input  logic [tsbg_pkg::DIV_DSR_W-1:0]    divisor,
	output logic                              done,
	output logic [tsbg_pkg::DIV_DVD_W-1:0]    quotient
);

	localparam int DVD_W  = tsbg_pkg::DIV_DVD_W;
	localparam int DSR_W  = tsbg_pkg::DIV_DSR_W;
	localparam int STEPS  = tsbg_pkg::DIV_BITS_PER_CYCLE;
	localparam int CYCLES = DVD_W / STEPS;
	localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;

	logic [DSR_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W-1:0] rem_w;
	logic [DVD_W-1:0] quo_w;

	always_comb begin
		logic [DSR_W:0] trial;
		logic           qbit;
		rem_w = rem_q;
		quo_w = quo_q;
		for (int s = 0; s < STEPS; s++) begin
			trial = {rem_w, quo_w[DVD_W-1]};
			qbit  = trial >= {1'b0, dsr_q};
			if (qbit) begin
				trial = trial - {1'b0, dsr_q};
			end
			rem_w = trial[DSR_W-1:0];
			quo_w = {quo_w[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_w;
			quo_q <= quo_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(CYCLES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/tsbg_back.sv -----
// ----------------------------------------------------------------------------
// tsbg_back
// Phase-to-gain lookup, interpolation and stereo scaling with output register.
// ----------------------------------------------------------------------------
module tsbg_back #(
	parameter int NUM_POINTS = tsbg_pkg::NUM_POINTS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic [NUM_POINTS-1:0][tsbg_pkg::POINT_W-1:0]      points,
	input  logic [tsbg_pkg::PHASE_W-1:0]                      period,
	input  tsbg_pkg::queue_stat_t                             q_stat,
	input  tsbg_pkg::item_t                                   q_head,
	output logic                                              pop,
	output logic                                              out_valid,
	input  logic                                              out_stall,
	output logic signed [tsbg_pkg::SAMPLE_W-1:0]              left_out,
	output logic signed [tsbg_pkg::SAMPLE_W-1:0]              right_out
);

	localparam int SW    = tsbg_pkg::SAMPLE_W;
	localparam int CW    = tsbg_pkg::COORD_W;
	localparam int PW    = tsbg_pkg::PHASE_W;
	localparam int DVD_W = tsbg_pkg::DIV_DVD_W;
	localparam int DSR_W = tsbg_pkg::DIV_DSR_W;
	localparam int DIF_W = CW + 1;
	localparam int PRD_W = 2 * DIF_W;
	localparam int GN_W  = DVD_W + 2;
	localparam int MUL_W = SW + CW + 1;
	localparam int SHR   = 15;
	localparam int SHF_W = MUL_W - SHR;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DIV1   = 8'b0000_0010,
		S_SEG    = 8'b0000_0100,
		S_PROD   = 8'b0000_1000,
		S_DSTART = 8'b0001_0000,
		S_DIV2   = 8'b0010_0000,
		S_SCALE  = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t                     state_q;
	logic signed [SW-1:0]       left_q;
	logic signed [SW-1:0]       right_q;
	logic [CW-1:0]              x0_q;
	tsbg_pkg::segment_t         seg_q;
	tsbg_pkg::segment_t         seg_w;
	logic signed [PRD_W-1:0]    prod_q;
	logic signed [DIF_W-1:0]    den_q;
	logic                       neg_q;
	logic [CW-1:0]              gain_q;
	logic signed [MUL_W-1:0]    mul_l_q;
	logic signed [MUL_W-1:0]    mul_r_q;
	logic                       out_valid_q;
	logic signed [SW-1:0]       left_out_q;
	logic signed [SW-1:0]       right_out_q;

	logic                       div_start;
	logic [DVD_W-1:0]           div_dvd;
	logic [DSR_W-1:0]           div_dsr;
	logic                       div_done;
	logic [DVD_W-1:0]           div_quo;

	logic                       flat;
	logic signed [PRD_W-1:0]    prod_abs;
	logic signed [DIF_W-1:0]    den_abs;
	logic signed [GN_W-1:0]     quo_s;
	logic signed [GN_W-1:0]     gain_w;
	logic                       out_free;

	function automatic logic signed [SW-1:0] sat(input logic signed [MUL_W-1:0] p);
		logic signed [SHF_W-1:0] r;
		r = SHF_W'(p >>> SHR);
		if (r > SHF_W'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
			return {1'b0, {(SW-1){1'b1}}};
		end else if (r < -SHF_W'(signed'({1'b0, 1'b1, {(SW-1){1'b0}}}))) begin
			return {1'b1, {(SW-1){1'b0}}};
		end
		return r[SW-1:0];
	endfunction

	always_comb begin
		seg_w.x1 = points[NUM_POINTS-2][2*CW-1:CW];
		seg_w.y1 = points[NUM_POINTS-2][CW-1:0];
		seg_w.x2 = points[NUM_POINTS-1][2*CW-1:CW];
		seg_w.y2 = points[NUM_POINTS-1][CW-1:0];
		for (int i = NUM_POINTS - 2; i >= 1; i--) begin
			if (x0_q <= points[i][2*CW-1:CW]) begin
				seg_w.x1 = points[i-1][2*CW-1:CW];
				seg_w.y1 = points[i-1][CW-1:0];
				seg_w.x2 = points[i][2*CW-1:CW];
				seg_w.y2 = points[i][CW-1:0];
			end
		end
	end

	always_comb begin
		flat     = (x0_q == seg_q.x1) || (seg_q.y1 == seg_q.y2) || (seg_q.x2 == seg_q.x1);
		prod_abs = prod_q[PRD_W-1] ? -prod_q : prod_q;
		den_abs  = den_q[DIF_W-1] ? -den_q : den_q;
		quo_s    = neg_q ? -signed'({2'b00, div_quo}) : signed'({2'b00, div_quo});
		gain_w   = signed'(GN_W'(seg_q.y1)) + quo_s;
		pop      = (state_q == S_IDLE) && q_stat.valid;
		out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = {1'b0, q_head.phase, {(DVD_W-PW-1){1'b0}}};
		div_dsr   = period;
		if (pop && (period != '0)) begin
			div_start = 1'b1;
		end else if (state_q == S_DSTART) begin
			div_start = 1'b1;
			div_dvd   = prod_abs[DVD_W-1:0];
			div_dsr   = den_abs[DSR_W-1:0];
		end
	end

	tsbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				left_q  <= q_head.left;
				right_q <= q_head.right;
				x0_q    <= '0;
			end
			S_DIV1: begin
				x0_q <= div_quo[CW-1:0];
			end
			S_SEG: begin
				seg_q <= seg_w;
			end
			S_PROD: begin
				gain_q <= seg_q.y1;
				prod_q <= signed'({1'b0, seg_q.y2} - {1'b0, seg_q.y1})
				        * signed'({1'b0, x0_q} - {1'b0, seg_q.x1});
				den_q  <= signed'({1'b0, seg_q.x2} - {1'b0, seg_q.x1});
			end
			S_DSTART: begin
				neg_q <= prod_q[PRD_W-1] ^ den_q[DIF_W-1];
			end
			S_DIV2: begin
				if (gain_w < 0) begin
					gain_q <= '0;
				end else if (gain_w > signed'(GN_W'({CW{1'b1}}))) begin
					gain_q <= '1;
				end else begin
					gain_q <= gain_w[CW-1:0];
				end
			end
			S_SCALE: begin
				mul_l_q <= left_q * signed'({1'b0, gain_q});
				mul_r_q <= right_q * signed'({1'b0, gain_q});
			end
			S_OUT: begin
				if (out_free) begin
					left_out_q  <= sat(mul_l_q);
					right_out_q <= sat(mul_r_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= (period != '0) ? S_DIV1 : S_SEG;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_SEG;
					end
				end
				S_SEG: begin
					state_q <= S_PROD;
				end
				S_PROD: begin
					state_q <= flat ? S_SCALE : S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider finished outside a divide state");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEG) |-> !x0_q[CW-1])
		else $error("phase reached 1.0");

	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> ($past(state_q) == S_SCALE || $past(state_q) == S_OUT))
		else $error("output state entered without scaling");

endmodule

// ----- tb/tb_tempo_synced_breakpoint_gain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tempo_synced_breakpoint_gain
// Self-checking bench for the tempo-synced breakpoint tremolo. A queue-fed
// driver offers stereo items with random gaps. A monitor predicts each scaled
// pair at acceptance, using its own LFO phase and shape state, and compares
// every result in order. Runs go through several shapes and periods: flat,
// degenerate, unsorted, zero period and gain above unity.
// ----------------------------------------------------------------------------
module tb_tempo_synced_breakpoint_gain;

	localparam int SAMPLE_W    = tsbg_pkg::SAMPLE_W;
	localparam int PHASE_W     = tsbg_pkg::PHASE_W;
	localparam int FRAC_W      = tsbg_pkg::FRAC_W;
	localparam int POINT_W     = tsbg_pkg::POINT_W;
	localparam int CFG_W       = tsbg_pkg::CFG_W;
	localparam int NPTS        = tsbg_pkg::NUM_POINTS_DEF;
	localparam int GROUP       = tsbg_pkg::GROUP_SIZE_DEF;
	localparam int IDX_W       = $clog2(NPTS + 1);
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 64;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 170;

	localparam int REG_POINT_A = 0;
	localparam int REG_PERIOD  = 5;

	localparam logic [POINT_W-1:0] POINT_MAX = 32'h8000_8000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       play;
		logic        [FRAC_W-1:0]   frac;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} pair_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] left_in = '0;
	logic signed [SAMPLE_W-1:0] right_in = '0;
	logic                       playing = 1'b0;
	logic        [FRAC_W-1:0]   beat_fraction = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;

	tempo_synced_breakpoint_gain dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_in       (left_in),
		.right_in      (right_in),
		.playing       (playing),
		.beat_fraction (beat_fraction),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.left_out      (left_out),
		.right_out     (right_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [POINT_W-1:0] shape_pts [NPTS];
	logic [PHASE_W-1:0] lfo_period;
	logic [PHASE_W-1:0] lfo_phase;
	int                 sub_count;
	logic               transport_was_on;

	frame_t frame_queue [$];
	pair_t  scaled_pairs [$];
	frame_t offered;

	bit in_taken;
	bit out_taken;
	bit quiet;
	int quiet_cycles;
	int fail_count;
	int src_gap;
	int sink_gap;
	int hold_left;
	int hold_requests;
	int hold_served;
	bit play_now;

	function automatic logic [15:0] shape_gain(input logic [15:0] ph);
		int     seg;
		longint xp, x1, y1, x2, y2, g;
		seg = 1;
		while (seg < NPTS - 1 && ph > shape_pts[seg][31:16])
			seg++;
		xp = longint'(ph);
		x1 = longint'(shape_pts[seg-1][31:16]);
		y1 = longint'(shape_pts[seg-1][15:0]);
		x2 = longint'(shape_pts[seg][31:16]);
		y2 = longint'(shape_pts[seg][15:0]);
		if (xp == x1 || y1 == y2 || x2 == x1)
			return y1[15:0];
		g = y1 + ((y2 - y1) * (xp - x1)) / (x2 - x1);
		if (g < 0)
			g = 0;
		if (g > 65535)
			g = 65535;
		return g[15:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] sat_scale(input logic signed [SAMPLE_W-1:0] smp,
		input logic [15:0] g);
		longint p;
		p = longint'(smp) * longint'(g);
		p = p >>> 15;
		if (p > 64'sd8388607)
			p = 64'sd8388607;
		if (p < -64'sd8388608)
			p = -64'sd8388608;
		return p[SAMPLE_W-1:0];
	endfunction

	function automatic pair_t tremolo_predict(input frame_t f);
		pair_t       res;
		logic [31:0] prod;
		logic [31:0] quot;
		logic [15:0] x0;
		logic [15:0] g;
		if (f.play) begin
			if (!transport_was_on) begin
				transport_was_on = 1'b1;
				prod = f.frac * lfo_period;
				lfo_phase = prod[31:16];
			end
		end else begin
			transport_was_on = 1'b0;
		end
		if (lfo_phase >= lfo_period)
			lfo_phase = '0;
		x0 = '0;
		if (lfo_period != 0) begin
			quot = {1'b0, lfo_phase, 15'd0} / {16'd0, lfo_period};
			x0 = quot[15:0];
		end
		g = shape_gain(x0);
		res.left = sat_scale(f.left, g);
		res.right = sat_scale(f.right, g);
		if (sub_count + 1 >= GROUP) begin
			sub_count = 0;
			lfo_phase = lfo_phase + 16'd1;
		end else begin
			sub_count++;
		end
		return res;
	endfunction

	// driver: next item goes out once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (frame_queue.size() > 0) begin
				offered = frame_queue.pop_front();
				left_in <= offered.left;
				right_in <= offered.right;
				playing <= offered.play;
				beat_fraction <= offered.frac;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (sink_gap > 0) begin
			sink_gap--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			sink_gap = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		pair_t want;
		in_taken = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (out_taken) begin
			if (scaled_pairs.size() == 0) begin
				fail_count++;
				$display("%0t: result with no item pending: left %h right %h",
					$time, left_out, right_out);
			end else begin
				want = scaled_pairs.pop_front();
				if (left_out !== want.left) begin
					fail_count++;
					$display("%0t: left_out expected %h actual %h",
						$time, want.left, left_out);
				end
				if (right_out !== want.right) begin
					fail_count++;
					$display("%0t: right_out expected %h actual %h",
						$time, want.right, right_out);
				end
			end
		end
		if (in_taken)
			scaled_pairs.push_back(tremolo_predict(offered));
		if (in_taken || out_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL tempo_synced_breakpoint_gain");
		$finish;
	end

	task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx[IDX_W-1:0];
		cfg_data <= val;
		if (idx < NPTS)
			shape_pts[idx] = val;
		else
			lfo_period = val[PHASE_W-1:0];
	endtask

	task automatic write_shape(input logic [POINT_W-1:0] pts [NPTS],
		input logic [PHASE_W-1:0] period);
		for (int i = 0; i < NPTS; i++)
			write_reg(REG_POINT_A + i, pts[i]);
		write_reg(REG_PERIOD, {16'd0, period});
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (frame_queue.size() != 0 || in_valid || scaled_pairs.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
		input logic p, input logic [FRAC_W-1:0] f);
		frame_t fr;
		fr.left = l;
		fr.right = r;
		fr.play = p;
		fr.frac = f;
		frame_queue.push_back(fr);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2: return 24'h00_0000;
			3: return 24'hFF_FFFF;
			default: return r[SAMPLE_W-1:0];
		endcase
	endfunction

	function automatic logic [POINT_W-1:0] make_point(input logic [15:0] x, input logic [15:0] y);
		if (x >= 16'h8000 && y > 16'h8000)
			y = 16'h8000;
		return {x, y};
	endfunction

	task automatic random_shape(input int kind);
		logic [POINT_W-1:0] pts [NPTS];
		logic [15:0]        xs [NPTS];
		logic [15:0]        ys [NPTS];
		logic [15:0]        tmp;
		logic [PHASE_W-1:0] period;
		for (int i = 0; i < NPTS; i++) begin
			xs[i] = 16'($urandom_range(0, 16'h8000));
			ys[i] = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 16'hFFFF))
				: 16'($urandom_range(0, 16'h8000));
		end
		for (int i = 0; i < NPTS; i++)
			for (int j = 0; j < NPTS - 1 - i; j++)
				if (xs[j] > xs[j+1]) begin
					tmp = xs[j];
					xs[j] = xs[j+1];
					xs[j+1] = tmp;
				end
		if (kind == 1) begin
			for (int i = 1; i < NPTS; i++) begin
				if ($urandom_range(0, 2) == 0)
					xs[i] = xs[i-1];
				if ($urandom_range(0, 2) == 0)
					ys[i] = ys[i-1];
			end
		end
		for (int i = 0; i < NPTS; i++)
			pts[i] = (kind == 2) ? $urandom_range(0, POINT_MAX) : make_point(xs[i], ys[i]);
		case (kind)
			0: period = 16'($urandom_range(1, 48));
			1: period = 16'($urandom_range(1, 400));
			default: period = ($urandom_range(0, 7) == 0) ? 16'd0
				: 16'($urandom_range(0, 16'hFFFF));
		endcase
		write_shape(pts, period);
	endtask

	initial begin
		logic [POINT_W-1:0] pts [NPTS];
		for (int i = 0; i < NPTS; i++)
			shape_pts[i] = tsbg_pkg::POINT_RESET[i];
		lfo_period = tsbg_pkg::PERIOD_RESET;
		lfo_phase = '0;
		sub_count = 0;
		transport_was_on = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default shape: zero gain in the first half of the period, unity gain in the second half
		push_frame(24'h00_0000, 24'h00_0000, 1'b0, 16'h0000);
		push_frame(24'h7F_FFFF, 24'h80_0000, 1'b1, 16'hFFFF);
		push_frame(24'h80_0000, 24'h7F_FFFF, 1'b1, 16'h0000);
		push_frame(24'hFF_FFFF, 24'h00_0001, 1'b1, 16'h1234);
		push_frame(24'h00_0000, 24'hFF_FFFF, 1'b0, 16'hFFFF);
		push_frame(24'h12_3456, 24'hED_CBA9, 1'b1, 16'h8000);
		push_frame(24'h00_0000, 24'h00_0000, 1'b0, 16'h0000);
		push_frame(24'h40_0000, 24'hC0_0000, 1'b1, 16'h4000);
		drain();

		// zero period, gain just under 2.0: full-scale outputs saturate
		pts[0] = 32'h0000_FFFF;
		pts[1] = 32'h7FFF_0000;
		pts[2] = 32'h7FFF_FFFF;
		pts[3] = POINT_MAX;
		pts[4] = 32'h8000_0000;
		write_shape(pts, 16'd0);
		push_frame(24'h7F_FFFF, 24'h80_0000, 1'b1, 16'h0000);
		push_frame(24'h80_0000, 24'h7F_FFFF, 1'b0, 16'hFFFF);
		push_frame(24'h40_0000, 24'hC0_0000, 1'b1, 16'hFFFF);
		drain();

		// unsorted shape with a repeated x: extrapolation clamps low
		pts[0] = 32'h4000_8000;
		pts[1] = 32'h6000_FFFF;
		pts[2] = 32'h6000_1000;
		pts[3] = 32'h1000_2000;
		pts[4] = 32'h2000_7000;
		write_shape(pts, 16'd4);
		for (int i = 0; i < 4; i++) begin
			push_frame(24'h12_3456, 24'hDC_BA98, 1'b0, 16'h0000);
			push_frame(24'h7F_FFFF, 24'h80_0000, 1'b1, 16'(i * 16'h4000));
		end
		drain();

		play_now = 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				for (int i = 0; i < NPTS; i++)
					pts[i] = POINT_MAX;
				write_shape(pts, 16'hFFFF);
			end else if (p == 1) begin
				for (int i = 0; i < NPTS; i++)
					pts[i] = '0;
				write_shape(pts, 16'd1);
			end else begin
				random_shape(p % 3);
			end
			if (p == PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (play_now)
					play_now = ($urandom_range(0, 24) != 0);
				else
					play_now = ($urandom_range(0, 1) != 0);
				push_frame(rand_sample(), rand_sample(), play_now, 16'($urandom()));
			end
			if (p == 3)
				hold_requests++;
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS tempo_synced_breakpoint_gain");
		else
			$display("FAIL tempo_synced_breakpoint_gain");
		$finish;
	end

endmodule
